### design/dltq_pkg.sv
// shared constants, codes and types of the delta-list timer queue
// no dependencies; every other design file refers to it by scoped names
package dltq_pkg;

  localparam int SLOTS      = 16;
  localparam int ID_COUNT   = 256;
  localparam int DELAY_BITS = 32;
  localparam int ID_BITS    = 8;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 3;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int FLAG_W     = $clog2(ID_COUNT);

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEL    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] ST_ACTIVE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO       = 3'd3;
  localparam logic [STAT_W-1:0] ST_DELETED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 3'd5;
  localparam logic [STAT_W-1:0] ST_EXPIRED    = 3'd6;
  localparam logic [STAT_W-1:0] ST_TICK_DONE  = 3'd7;

  typedef logic [DELAY_BITS-1:0] delay_t;
  typedef logic [ID_BITS-1:0]    tid_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             wr;
    logic             mod_en;
    logic [IDX_W-1:0] pos;
    tid_t             id;
    delay_t           delta;
    delay_t           mod_delta;
  } list_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    tid_t              id;
    logic              last;
  } emit_t;

  typedef struct packed {
    logic   sub;
    delay_t a;
    delay_t b;
  } alu_op_t;

endpackage

### design/dltq_ifs.sv
// valid/ready channel interfaces for requests and results
// depends on dltq_pkg
interface dltq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dltq_pkg::REQ_W-1:0]  req_type;
  dltq_pkg::tid_t              timer_id;
  dltq_pkg::delay_t            delay;

  modport source (output valid, output req_type, output timer_id, output delay, input ready);
  modport sink   (input valid, input req_type, input timer_id, input delay, output ready);
endinterface

interface dltq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dltq_pkg::STAT_W-1:0] status;
  dltq_pkg::tid_t              result_id;
  logic                        last;

  modport source (output valid, output status, output result_id, output last, input ready);
  modport sink   (input valid, input status, input result_id, input last, output ready);
endinterface

### design/delta_list_timer_queue.sv
// delta-list timer queue top level: sequencer, entry store, shared unit, result register
// depends on dltq_pkg, dltq_ifs, dltq_alu, dltq_list, dltq_seq
//
// in_ch takes one request per transaction: add (timer_id, delay), delete (timer_id) or tick.
// out_ch returns the results of that request in order; the final one has last set.
// add/delete return one result; a tick returns one expired result per timer that runs out,
// then a tick-done result. request type 3 is taken and dropped without a result.
// in_ch.ready is high only while the sequencer is idle, one request at a time.
// add walks the entries one entry per cycle (up to 15, as a full list is refused) through
// the single shared add/subtract unit; delete walks the list the same way in its id search.
// tick decrements the head delta, then removes and reports each expired head entry.
// a pending result in the output register does not stop the next request being taken.
// reset (rst_n low, synchronous) empties the list and clears every active flag;
// no clearing pass is needed afterwards.
// when out_ch stalls the result is held and the sequencer waits before emitting the next.
module delta_list_timer_queue (
  input  logic              clk,
  input  logic              rst_n,
  dltq_in_if.sink           in_ch,
  dltq_out_if.source        out_ch
);

  dltq_pkg::emit_t               emit;
  dltq_pkg::list_cmd_t           cmd;
  dltq_pkg::alu_op_t             alu_op;
  dltq_pkg::delay_t              alu_res;
  logic                          alu_borrow;
  logic [dltq_pkg::IDX_W-1:0]    rd_idx;
  dltq_pkg::tid_t                rd_id;
  dltq_pkg::delay_t              rd_delta;
  logic [dltq_pkg::CNT_W-1:0]    entry_count;
  logic                          out_free;

  logic                          out_valid_r;
  logic [dltq_pkg::STAT_W-1:0]   out_status_r;
  dltq_pkg::tid_t                out_id_r;
  logic                          out_last_r;

  assign out_free = !out_valid_r || out_ch.ready;

  dltq_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_timer_id (in_ch.timer_id),
    .in_delay    (in_ch.delay),
    .in_ready    (in_ch.ready),
    .out_free    (out_free),
    .emit        (emit),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .rd_id       (rd_id),
    .rd_delta    (rd_delta),
    .count       (entry_count),
    .alu_op      (alu_op),
    .alu_res     (alu_res),
    .alu_borrow  (alu_borrow)
  );

  dltq_list u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .rd_id    (rd_id),
    .rd_delta (rd_delta),
    .count    (entry_count)
  );

  dltq_alu u_alu (
    .op     (alu_op),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_status_r <= emit.status;
      out_id_r     <= emit.id;
      out_last_r   <= emit.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.result_id = out_id_r;
  assign out_ch.last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(entry_count) <= dltq_pkg::SLOTS)
    else $error("entry count beyond list size");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> int'(entry_count) < dltq_pkg::SLOTS)
    else $error("insert into a full list");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result register overwritten while held");

  a_mid_is_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_status_r == dltq_pkg::ST_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.req_type != dltq_pkg::REQ_UNUSED |=> !in_ch.ready)
    else $error("request taken while previous one still in progress");

endmodule

### design/dltq_alu.sv
// shared add/subtract unit used by the walk, insert, fold and tick steps of the sequencer
// depends on dltq_pkg
module dltq_alu (
  input  dltq_pkg::alu_op_t op,
  output dltq_pkg::delay_t  res,
  output logic              borrow
);

  logic [dltq_pkg::DELAY_BITS:0] sum;
  dltq_pkg::delay_t              b_eff;

  assign b_eff  = op.sub ? ~op.b : op.b;
  assign sum    = {1'b0, op.a} + {1'b0, b_eff} + {{dltq_pkg::DELAY_BITS{1'b0}}, op.sub};
  assign res    = sum[dltq_pkg::DELAY_BITS-1:0];
  assign borrow = op.sub & ~sum[dltq_pkg::DELAY_BITS];

endmodule

### design/dltq_list.sv
// ordered entry store: ids and relative deltas with parallel insert/remove shifting
// depends on dltq_pkg
module dltq_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dltq_pkg::list_cmd_t           cmd,
  input  logic [dltq_pkg::IDX_W-1:0]    rd_idx,
  output dltq_pkg::tid_t                rd_id,
  output dltq_pkg::delay_t              rd_delta,
  output logic [dltq_pkg::CNT_W-1:0]    count
);

  dltq_pkg::tid_t             ids_r    [dltq_pkg::SLOTS];
  dltq_pkg::delay_t           deltas_r [dltq_pkg::SLOTS];
  logic [dltq_pkg::CNT_W-1:0] count_r, count_nxt;

  assign rd_id    = ids_r[rd_idx];
  assign rd_delta = deltas_r[rd_idx];
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + dltq_pkg::CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - dltq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      for (int i = 1; i < dltq_pkg::SLOTS; i++) begin
        if (dltq_pkg::IDX_W'(i) > cmd.pos) begin
          ids_r[i]    <= ids_r[i-1];
          deltas_r[i] <= (cmd.mod_en && dltq_pkg::IDX_W'(i) == cmd.pos + dltq_pkg::IDX_W'(1))
                         ? cmd.mod_delta : deltas_r[i-1];
        end
      end
      ids_r[cmd.pos]    <= cmd.id;
      deltas_r[cmd.pos] <= cmd.delta;
    end else if (cmd.rem) begin
      for (int i = 0; i < dltq_pkg::SLOTS - 1; i++) begin
        if (dltq_pkg::IDX_W'(i) >= cmd.pos) begin
          ids_r[i]    <= ids_r[i+1];
          deltas_r[i] <= (cmd.mod_en && dltq_pkg::IDX_W'(i) == cmd.pos)
                         ? cmd.mod_delta : deltas_r[i+1];
        end
      end
    end else if (cmd.wr) begin
      deltas_r[cmd.pos] <= cmd.delta;
    end
  end

endmodule

### design/dltq_seq.sv
// sequencer: walks the list one entry per cycle through the shared unit, keeps active flags
// depends on dltq_pkg; drives dltq_list commands and dltq_alu operands
module dltq_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [dltq_pkg::REQ_W-1:0]    in_req_type,
  input  dltq_pkg::tid_t                in_timer_id,
  input  dltq_pkg::delay_t              in_delay,
  output logic                          in_ready,
  input  logic                          out_free,
  output dltq_pkg::emit_t               emit,
  output dltq_pkg::list_cmd_t           cmd,
  output logic [dltq_pkg::IDX_W-1:0]    rd_idx,
  input  dltq_pkg::tid_t                rd_id,
  input  dltq_pkg::delay_t              rd_delta,
  input  logic [dltq_pkg::CNT_W-1:0]    count,
  output dltq_pkg::alu_op_t             alu_op,
  input  dltq_pkg::delay_t              alu_res,
  input  logic                          alu_borrow
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_TICK = 3'd5;
  localparam logic [2:0] S_POP  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [dltq_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  dltq_pkg::delay_t              rest_r, rest_nxt;
  dltq_pkg::tid_t                id_r, id_nxt;
  logic [dltq_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic [dltq_pkg::ID_COUNT-1:0] active_r;

  logic                          act_set, act_clr;
  logic [dltq_pkg::FLAG_W-1:0]   act_idx;
  logic                          in_range, gone_in_range, in_active;
  logic                          pos_lt_cnt, next_lt_cnt;
  logic [dltq_pkg::CNT_W-1:0]    pos_inc;

  assign in_ready      = (state_r == S_IDLE);
  assign in_range      = int'(in_timer_id) < dltq_pkg::ID_COUNT;
  assign gone_in_range = int'(rd_id) < dltq_pkg::ID_COUNT;
  assign in_active     = in_range && active_r[in_timer_id[dltq_pkg::FLAG_W-1:0]];
  assign pos_inc       = pos_r + dltq_pkg::CNT_W'(1);
  assign pos_lt_cnt    = pos_r < count;
  assign next_lt_cnt   = pos_inc < count;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    rest_nxt   = rest_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    cmd        = '0;
    emit       = '0;
    alu_op     = '0;
    rd_idx     = pos_r[dltq_pkg::IDX_W-1:0];
    act_set    = 1'b0;
    act_clr    = 1'b0;
    act_idx    = id_r[dltq_pkg::FLAG_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt   = in_timer_id;
          rest_nxt = in_delay;
          pos_nxt  = '0;
          case (in_req_type)
            dltq_pkg::REQ_ADD: begin
              state_nxt = S_RESP;
              if (int'(count) >= dltq_pkg::SLOTS || !in_range) begin
                status_nxt = dltq_pkg::ST_FULL;
              end else if (in_active) begin
                status_nxt = dltq_pkg::ST_ACTIVE;
              end else if (in_delay == '0) begin
                status_nxt = dltq_pkg::ST_ZERO;
              end else begin
                state_nxt = S_WALK;
              end
            end
            dltq_pkg::REQ_DEL: begin
              if (!in_active) begin
                status_nxt = dltq_pkg::ST_NOT_ACTIVE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_FIND;
              end
            end
            dltq_pkg::REQ_TICK: state_nxt = S_TICK;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        alu_op = '{sub: 1'b1, a: rest_r, b: rd_delta};
        if (pos_lt_cnt && !alu_borrow) begin
          rest_nxt = alu_res;
          pos_nxt  = pos_inc;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        alu_op        = '{sub: 1'b1, a: rd_delta, b: rest_r};
        cmd.ins       = 1'b1;
        cmd.pos       = pos_r[dltq_pkg::IDX_W-1:0];
        cmd.id        = id_r;
        cmd.delta     = rest_r;
        cmd.mod_en    = pos_lt_cnt;
        cmd.mod_delta = alu_res;
        act_set       = 1'b1;
        status_nxt    = dltq_pkg::ST_ADDED;
        state_nxt     = S_RESP;
      end
      S_FIND: begin
        if (!pos_lt_cnt) begin
          act_clr    = 1'b1;
          status_nxt = dltq_pkg::ST_DELETED;
          state_nxt  = S_RESP;
        end else if (rd_id == id_r) begin
          rest_nxt  = rd_delta;
          state_nxt = S_FOLD;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      S_FOLD: begin
        rd_idx        = pos_inc[dltq_pkg::IDX_W-1:0];
        alu_op        = '{sub: 1'b0, a: rd_delta, b: rest_r};
        cmd.rem       = 1'b1;
        cmd.pos       = pos_r[dltq_pkg::IDX_W-1:0];
        cmd.mod_en    = next_lt_cnt;
        cmd.mod_delta = alu_res;
        act_clr       = 1'b1;
        status_nxt    = dltq_pkg::ST_DELETED;
        state_nxt     = S_RESP;
      end
      S_TICK: begin
        rd_idx    = '0;
        alu_op    = '{sub: 1'b1, a: rd_delta, b: dltq_pkg::DELAY_BITS'(1)};
        cmd.wr    = (count != '0) && (rd_delta != '0);
        cmd.pos   = '0;
        cmd.delta = alu_res;
        state_nxt = S_POP;
      end
      S_POP: begin
        rd_idx = '0;
        if (out_free) begin
          if (count != '0 && rd_delta == '0) begin
            emit    = '{valid: 1'b1, status: dltq_pkg::ST_EXPIRED, id: rd_id, last: 1'b0};
            cmd.rem = 1'b1;
            cmd.pos = '0;
            act_idx = rd_id[dltq_pkg::FLAG_W-1:0];
            act_clr = gone_in_range;
          end else begin
            emit      = '{valid: 1'b1, status: dltq_pkg::ST_TICK_DONE, id: '0, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit      = '{valid: 1'b1, status: status_r, id: id_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (act_set) begin
        active_r[act_idx] <= 1'b1;
      end else if (act_clr) begin
        active_r[act_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    rest_r   <= rest_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
  end

endmodule

### bench/dltq_checker.sv
`timescale 1ns / 100ps
// result checker for the delta-list timer queue: watches both channels, keeps its own
// copy of the timer list, predicts the results of every request and compares them in order
// depends on dltq_pkg and dltq_ifs
module dltq_checker (
  input  logic        clk,
  input  logic        rst_n,
  dltq_in_if          in_mon,
  dltq_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    logic [dltq_pkg::STAT_W-1:0] status;
    dltq_pkg::tid_t              id;
    logic                        last;
  } timer_result_t;

  dltq_pkg::tid_t   list_id [dltq_pkg::SLOTS];
  dltq_pkg::delay_t list_dt [dltq_pkg::SLOTS];
  int               list_len;
  bit               armed [dltq_pkg::ID_COUNT];
  timer_result_t    due_q [$];
  timer_result_t    want;
  int unsigned      errs;

  function automatic void queue_result(logic [dltq_pkg::STAT_W-1:0] status,
                                       dltq_pkg::tid_t id, logic last);
    timer_result_t r;
    r.status = status;
    r.id     = id;
    r.last   = last;
    due_q.push_back(r);
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_id[i] = list_id[i + 1];
      list_dt[i] = list_dt[i + 1];
    end
    list_len--;
  endfunction

  function automatic logic [dltq_pkg::STAT_W-1:0] timer_add(dltq_pkg::tid_t id,
                                                            dltq_pkg::delay_t dl);
    dltq_pkg::delay_t rest;
    int               pos;
    rest = dl;
    if (list_len >= dltq_pkg::SLOTS) return dltq_pkg::ST_FULL;
    if (armed[id]) return dltq_pkg::ST_ACTIVE;
    if (rest == '0) return dltq_pkg::ST_ZERO;
    pos = 0;
    while (pos < list_len && rest >= list_dt[pos]) begin
      rest = rest - list_dt[pos];
      pos++;
    end
    if (pos < list_len) list_dt[pos] = list_dt[pos] - rest;
    for (int i = list_len; i > pos; i--) begin
      list_id[i] = list_id[i - 1];
      list_dt[i] = list_dt[i - 1];
    end
    list_id[pos] = id;
    list_dt[pos] = rest;
    list_len++;
    armed[id] = 1'b1;
    return dltq_pkg::ST_ADDED;
  endfunction

  function automatic logic [dltq_pkg::STAT_W-1:0] timer_delete(dltq_pkg::tid_t id);
    int pos;
    if (!armed[id]) return dltq_pkg::ST_NOT_ACTIVE;
    pos = 0;
    while (pos < list_len && list_id[pos] != id) pos++;
    if (pos < list_len) begin
      if (pos + 1 < list_len) list_dt[pos + 1] = list_dt[pos + 1] + list_dt[pos];
      drop_entry(pos);
    end
    armed[id] = 1'b0;
    return dltq_pkg::ST_DELETED;
  endfunction

  function automatic void predict_request(logic [dltq_pkg::REQ_W-1:0] rt,
                                          dltq_pkg::tid_t id, dltq_pkg::delay_t dl);
    dltq_pkg::tid_t gone;
    case (rt)
      dltq_pkg::REQ_ADD: queue_result(timer_add(id, dl), id, 1'b1);
      dltq_pkg::REQ_DEL: queue_result(timer_delete(id), id, 1'b1);
      dltq_pkg::REQ_TICK: begin
        if (list_len > 0 && list_dt[0] != '0) list_dt[0] = list_dt[0] - 1'b1;
        while (list_len > 0 && list_dt[0] == '0) begin
          gone = list_id[0];
          drop_entry(0);
          armed[gone] = 1'b0;
          queue_result(dltq_pkg::ST_EXPIRED, gone, 1'b0);
        end
        queue_result(dltq_pkg::ST_TICK_DONE, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      foreach (armed[i]) armed[i] = 1'b0;
      due_q.delete();
      errs = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got status %0d id %0d last %0d",
                   $time, out_mon.status, out_mon.result_id, out_mon.last);
        end else begin
          want = due_q.pop_front();
          if (out_mon.status !== want.status || out_mon.result_id !== want.id ||
              out_mon.last !== want.last) begin
            errs++;
            $display("%0t: result mismatch: expected status %0d id %0d last %0d,",
                     $time, want.status, want.id, want.last,
                     " got status %0d id %0d last %0d",
                     out_mon.status, out_mon.result_id, out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.req_type, in_mon.timer_id, in_mon.delay);
    end
    fail_count <= errs;
    pending    <= due_q.size();
  end

endmodule

### bench/tb_delta_list_timer_queue.sv
`timescale 1ns / 100ps
// testbench top for the delta-list timer queue: clock, reset, request stimulus, result
// back-pressure and the verdict; prediction and comparison sit in dltq_checker
// depends on dltq_pkg, dltq_ifs, dltq_checker and delta_list_timer_queue
module tb_delta_list_timer_queue;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          TAIL_CYCLES  = 40;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int unsigned hold_asks;

  dltq_in_if  in_ch ();
  dltq_out_if out_ch ();

  delta_list_timer_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dltq_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    int unsigned wait_left;
    int unsigned hold_seen;
    int unsigned rdy_cycle;
    int unsigned r;
    out_ch.ready <= 1'b0;
    wait_left = 0;
    hold_seen = 0;
    rdy_cycle = 0;
    @(posedge clk);
    forever begin
      rdy_cycle++;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        wait_left = LONG_HOLD;
      end
      if (wait_left != 0) begin
        out_ch.ready <= 1'b0;
        wait_left--;
      end else if ((rdy_cycle / 1500) % 4 == 2) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          wait_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
      @(posedge clk);
    end
  end

  function automatic int unsigned req_gap(int n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (n >= 150 && n <= 190) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(input logic [dltq_pkg::REQ_W-1:0] rt, input dltq_pkg::tid_t id,
                          input dltq_pkg::delay_t dl, input int n);
    int unsigned gap;
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.timer_id <= id;
    in_ch.delay    <= dl;
    do @(posedge clk); while (!in_ch.ready);
    gap = req_gap(n);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_req(input int n, output bit counted);
    logic [dltq_pkg::REQ_W-1:0] rt;
    dltq_pkg::tid_t             id;
    dltq_pkg::delay_t           dl;
    int unsigned                r;
    int unsigned                mode;
    mode = (n / 40) % 3;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        rt = (r < 40) ? dltq_pkg::REQ_ADD : (r < 65) ? dltq_pkg::REQ_DEL :
             (r < 95) ? dltq_pkg::REQ_TICK : dltq_pkg::REQ_UNUSED;
      end
      1: begin
        rt = (r < 75) ? dltq_pkg::REQ_ADD : (r < 85) ? dltq_pkg::REQ_DEL :
             (r < 97) ? dltq_pkg::REQ_TICK : dltq_pkg::REQ_UNUSED;
      end
      default: begin
        rt = (r < 25) ? dltq_pkg::REQ_ADD : (r < 45) ? dltq_pkg::REQ_DEL :
             (r < 97) ? dltq_pkg::REQ_TICK : dltq_pkg::REQ_UNUSED;
      end
    endcase
    id = ($urandom_range(0, 99) < 88) ? dltq_pkg::tid_t'($urandom_range(0, 19))
                                      : dltq_pkg::tid_t'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 8)       dl = '0;
    else if (r < 78) dl = dltq_pkg::delay_t'($urandom_range(1, 12));
    else if (r < 88) dl = dltq_pkg::delay_t'($urandom);
    else if (r < 93) dl = '1 - dltq_pkg::delay_t'($urandom_range(0, 3));
    else             dl = dltq_pkg::delay_t'($urandom_range(13, 1000));
    send_req(rt, id, dl, n);
    counted = (rt != dltq_pkg::REQ_UNUSED);
  endtask

  initial begin
    int sent;
    bit counted;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= dltq_pkg::REQ_TICK;
    in_ch.timer_id <= '0;
    in_ch.delay    <= '0;
    hold_asks      <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, rejections, equal expiry ordering, fold on delete, full list
    send_req(dltq_pkg::REQ_TICK, '0, '0, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd0, 32'd1, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd0, 32'd5, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd1, '0, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd255, '1, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd2, 32'd1, 0);
    send_req(dltq_pkg::REQ_ADD, 8'd3, 32'd3, 0);
    send_req(dltq_pkg::REQ_DEL, 8'd7, '0, 0);
    send_req(dltq_pkg::REQ_DEL, 8'd3, '1, 0);
    send_req(dltq_pkg::REQ_UNUSED, 8'hAA, 32'h5555_5555, 0);
    send_req(dltq_pkg::REQ_TICK, 8'hFF, '1, 0);
    for (int i = 16; i <= 30; i++)
      send_req(dltq_pkg::REQ_ADD, dltq_pkg::tid_t'(i),
               dltq_pkg::delay_t'($urandom_range(2, 6)), 0);
    send_req(dltq_pkg::REQ_ADD, 8'd40, 32'd9, 0);
    send_req(dltq_pkg::REQ_DEL, 8'd255, '0, 0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 100) hold_asks <= hold_asks + 1;
      if (sent == 200) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      random_req(sent, counted);
      if (counted) sent++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
